### hdl/wide_unsigned_integer_alu_assert.svh
`ifndef WIDE_UNSIGNED_INTEGER_ALU_ASSERT_SVH
`define WIDE_UNSIGNED_INTEGER_ALU_ASSERT_SVH

// same-cycle implication
`define WUIA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("wuia check failed");

// next-cycle implication
`define WUIA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("wuia check failed");

`endif

### hdl/wuia_pkg.sv
package wuia_pkg;

   localparam int OP_WIDTH      = 5;
   localparam int OPERAND_WIDTH = 64;
   localparam int POS_WIDTH     = 7;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_AND    = 5'd2,
      OP_OR     = 5'd3,
      OP_XOR    = 5'd4,
      OP_SHL    = 5'd5,
      OP_SHR    = 5'd6,
      OP_MUL    = 5'd7,
      OP_DIV    = 5'd8,
      OP_MOD    = 5'd9,
      OP_LT     = 5'd10,
      OP_GT     = 5'd11,
      OP_LE     = 5'd12,
      OP_GE     = 5'd13,
      OP_EQ     = 5'd14,
      OP_NE     = 5'd15,
      OP_ISZERO = 5'd16,
      OP_ISODD  = 5'd17,
      OP_GETBIT = 5'd18,
      OP_SETBIT = 5'd19
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

### hdl/wide_unsigned_integer_alu.sv
// Unsigned ALU on N = 8*WIDTH_BYTES bit operands (upper port bits ignored), one item at a
// time. Every operation runs a bit-serial sequencer (one operand bit per cycle, LSB
// first, or one restoring-division / shift-add multiply step per cycle), and then the
// result is loaded into the output register. A new item is taken while the previous
// result still waits in the output register; the sequencer stalls only if a result is
// ready before the old one leaves.
module wide_unsigned_integer_alu #(
   parameter int WIDTH_BYTES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wuia_pkg::OP_WIDTH-1:0]        req_operation,
   input  logic [wuia_pkg::OPERAND_WIDTH-1:0]   req_operand_a,
   input  logic [wuia_pkg::OPERAND_WIDTH-1:0]   req_operand_b,
   input  logic [wuia_pkg::POS_WIDTH-1:0]       req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wuia_pkg::OPERAND_WIDTH-1:0]   rsp_result_value,
   output logic                                 rsp_result_flag
);
   import wuia_pkg::*;

`include "wide_unsigned_integer_alu_assert.svh"

   localparam int N  = 8 * WIDTH_BYTES;
   localparam int CW = $clog2(N);

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [POS_WIDTH-1:0]   pos_ff;
   logic [CW-1:0]          tgt_ff, tgt_in;
   logic                   in_range_ff, in_range_in;
   logic                   setv_ff;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [N-1:0]           x_ff, x_in;
   logic [N-1:0]           y_ff, y_in;
   logic [N-1:0]           z_ff, z_in;
   logic                   carry_ff, carry_in;
   logic                   lt_ff, lt_in;
   logic                   ne_ff, ne_in;
   logic                   pick_ff, pick_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_flag_ff;

   logic                   load;
   logic                   finish;
   logic                   out_free;
   logic                   last_step;
   logic                   ybit;
   logic [N-1:0]           rem_shift;
   logic                   rem_ge;
   logic [N-1:0]           val;
   logic                   flag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (cnt_ff == CW'(N - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_RUN:  req_stall = 1'b1;
         ST_DONE: finish    = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign load = req_valid && !req_stall;

   // target bit index for getbit, setbit and isodd
   always_comb begin
      in_range_in = (req_position < POS_WIDTH'(N));
      if (op_type'(req_operation) == OP_ISODD) begin
         tgt_in = '0;
      end else if (in_range_in) begin
         tgt_in = CW'(POS_WIDTH'(N - 1) - req_position);
      end else begin
         tgt_in = CW'(N - 1);
      end
   end

   assign rem_shift = {z_ff[N-2:0], x_ff[N-1]};
   assign rem_ge    = (rem_shift >= y_ff);
   assign ybit      = (op_ff == OP_SUB) ? ~y_ff[0] : y_ff[0];

   // bit-serial datapath
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      carry_in = carry_ff;
      lt_in    = lt_ff;
      ne_in    = ne_ff;
      pick_in  = pick_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         x_in     = req_operand_a[N-1:0];
         y_in     = (op_type'(req_operation) == OP_ISZERO) ? '0 : req_operand_b[N-1:0];
         z_in     = '0;
         carry_in = (op_type'(req_operation) == OP_SUB);
         lt_in    = 1'b0;
         ne_in    = 1'b0;
         pick_in  = 1'b0;
         cnt_in   = '0;
      end else if (state_ff == ST_RUN) begin
         cnt_in = cnt_ff + CW'(1);
         unique case (op_ff)
            OP_ADD, OP_SUB: begin
               z_in     = {x_ff[0] ^ ybit ^ carry_ff, z_ff[N-1:1]};
               carry_in = (x_ff[0] & ybit) | (x_ff[0] & carry_ff) | (ybit & carry_ff);
               x_in     = x_ff >> 1;
               y_in     = y_ff >> 1;
            end
            OP_AND, OP_OR, OP_XOR: begin
               priority if (op_ff == OP_AND) z_in = {x_ff[0] & y_ff[0], z_ff[N-1:1]};
               else if (op_ff == OP_OR)      z_in = {x_ff[0] | y_ff[0], z_ff[N-1:1]};
               else                          z_in = {x_ff[0] ^ y_ff[0], z_ff[N-1:1]};
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end
            OP_SHL: begin
               if (POS_WIDTH'(cnt_ff) < pos_ff) x_in = x_ff << 1;
            end
            OP_SHR: begin
               if (POS_WIDTH'(cnt_ff) < pos_ff) x_in = x_ff >> 1;
            end
            OP_MUL: begin
               if (y_ff[0]) z_in = z_ff + x_ff;
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            OP_DIV, OP_MOD: begin
               z_in = rem_ge ? (rem_shift - y_ff) : rem_shift;
               x_in = {x_ff[N-2:0], rem_ge};
            end
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE, OP_ISZERO: begin
               ne_in = ne_ff | (x_ff[0] ^ y_ff[0]);
               if (x_ff[0] != y_ff[0]) lt_in = y_ff[0];
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end
            OP_ISODD, OP_GETBIT: begin
               if (cnt_ff == tgt_ff) pick_in = x_ff[0];
               x_in = x_ff >> 1;
            end
            OP_SETBIT: begin
               z_in = {(in_range_ff && cnt_ff == tgt_ff) ? setv_ff : x_ff[0], z_ff[N-1:1]};
               x_in = x_ff >> 1;
            end
            default: begin
               x_in = x_ff;
            end
         endcase
      end
   end

   // result selection
   always_comb begin
      val  = '0;
      flag = 1'b0;
      unique case (op_ff)
         OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_MUL, OP_MOD: val = z_ff;
         OP_SHL, OP_SHR, OP_DIV:                                val = x_ff;
         OP_SETBIT: begin
            val  = z_ff;
            flag = in_range_ff;
         end
         OP_LT:                flag = lt_ff;
         OP_GT:                flag = ne_ff && !lt_ff;
         OP_LE:                flag = lt_ff || !ne_ff;
         OP_GE:                flag = !lt_ff;
         OP_EQ, OP_ISZERO:     flag = !ne_ff;
         OP_NE:                flag = ne_ff;
         OP_ISODD, OP_GETBIT:  flag = pick_ff;
         default:              val  = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      carry_ff <= carry_in;
      lt_ff    <= lt_in;
      ne_ff    <= ne_in;
      pick_ff  <= pick_in;
      cnt_ff   <= cnt_in;
      if (load) begin
         op_ff       <= op_type'(req_operation);
         pos_ff      <= req_position;
         tgt_ff      <= tgt_in;
         in_range_ff <= in_range_in;
         setv_ff     <= req_operand_b[0];
      end
      if (finish) begin
         rsp_value_ff <= OPERAND_WIDTH'(val);
         rsp_flag_ff  <= flag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_flag  = rsp_flag_ff;

   `WUIA_ASSERT_NEXT(a_load_starts_run, clock, reset, load, (state_ff == ST_RUN) && (cnt_ff == '0))
   `WUIA_ASSERT_NOW(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall)
   `WUIA_ASSERT_NEXT(a_result_from_done, clock, reset,
      (state_ff != ST_DONE) && !rsp_valid_ff, !rsp_valid_ff)

endmodule
